// ===== src/fpqs_pkg.sv =====
package fpqs_pkg;

    localparam int NUM_PARTITIONS_DEF = 3;
    localparam int QUEUE_DEPTH_DEF    = 8;

    localparam int NUM_REGS  = 3;
    localparam int REG_IDX_W = 2;
    localparam int REG_W     = 8;

    localparam logic [REG_W-1:0] SIZE_RESET [NUM_REGS] = '{8'd10, 8'd15, 8'd25};

    localparam int FIELD_W = 8;
    localparam int TIME_W  = 16;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 40;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic {
        KIND_ACK  = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_NO_FIT = 2'd1,
        CAUSE_FULL   = 2'd2
    } t_cause;

    typedef struct packed {
        logic                   accepted;
        t_cause                 reject_cause;
        logic [1:0]             partition_index;
        logic                   busy_res;
        logic [FIELD_W-1:0]     running_id;
        logic [FIELD_W-1:0]     time_left;
        logic                   finished;
        logic [TIME_W-1:0]      tick_time;
    } t_result;

endpackage

// ===== src/fixed_partition_queue_scheduler.sv =====
// Fixed-partition process scheduler with one FIFO queue per partition.
// Input stream (s_axis): tuser selects the command, add process or time tick;
// tdata carries proc_id, service_time and proc_size. Output stream (m_axis):
// tuser gives the result kind, tdata the result fields, tlast marks the last
// result of one input transaction. An add yields one acknowledgement, a tick
// yields one report per partition in index order.
// One transaction at a time: ready is high only while the sequencer idles.
// An add scans the partition sizes through one shared compare, one partition
// per cycle, and stops at the first partition that fits or, when none fits,
// at the last one. For each partition a tick reads the queue head from the
// queue memory; for a busy partition the remaining time is then decremented
// and written back, an empty partition goes straight to its report. Each
// report waits in the output register for its handshake.
// A stalled receiver holds the current result in the output register and
// halts the sequencer; nothing is dropped.
// Reset empties all queues, clears the tick counter and restores the
// partition sizes 10, 15 and 25. The queue memory is not cleared; only the
// head entry of a non-empty queue is used. The user must write partition
// sizes through the cfg port only while idle; the block does not enforce it.
module fixed_partition_queue_scheduler
    import fpqs_pkg::*;
#(
    parameter int NUM_PARTITIONS = NUM_PARTITIONS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // proc_id [7:0], service_time [15:8], proc_size [23:16]
    input  logic [IN_W-1:0]      i_s_axis_tdata,
    // cmd [0]
    input  logic                 i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // accepted [0], reject_cause [2:1], partition_index [4:3], busy_res [5],
    // running_id [13:6], time_left [21:14], finished [22], tick_time [38:23]
    output logic [OUT_W-1:0]     o_m_axis_tdata,
    // result_kind [0]
    output logic                 o_m_axis_tuser,
    output logic                 o_m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data
);

    localparam int IDX_W  = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_D  = NUM_PARTITIONS * QUEUE_DEPTH;
    localparam int ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam int ENT_W  = 2 * FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HEAD,
        S_SERVE,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [REG_W-1:0]    r_part_size [NUM_PARTITIONS];
    logic [PTR_W-1:0]    r_head      [NUM_PARTITIONS];
    logic [PTR_W-1:0]    r_tail      [NUM_PARTITIONS];
    logic [CNT_W-1:0]    r_count     [NUM_PARTITIONS];
    logic [TIME_W-1:0]   r_tick_count;
    logic [IDX_W-1:0]    r_idx;
    logic [FIELD_W-1:0]  r_id;
    logic [FIELD_W-1:0]  r_st;
    logic [FIELD_W-1:0]  r_size;

    logic [ENT_W-1:0]    r_mem [MEM_D];
    logic [ENT_W-1:0]    r_rdata;

    t_result             r_res;
    t_kind               r_kind;
    logic                r_valid;
    logic                r_last;

    logic                n_fit;
    logic                n_full;
    logic                n_last_part;
    logic [PTR_W-1:0]    n_ptr;
    logic [ADDR_W-1:0]   n_addr;
    logic                n_we;
    logic [ENT_W-1:0]    n_wdata;
    logic [FIELD_W-1:0]  n_left;
    logic                n_fin;
    logic [PTR_W-1:0]    n_head_next;
    logic [PTR_W-1:0]    n_tail_next;

    assign n_fit       = (r_part_size[r_idx] >= r_size);
    assign n_full      = (r_count[r_idx] == CNT_W'(QUEUE_DEPTH));
    assign n_last_part = (r_idx == IDX_W'(NUM_PARTITIONS - 1));
    assign n_ptr       = (r_state == S_SCAN) ? r_tail[r_idx] : r_head[r_idx];
    assign n_addr      = ADDR_W'(r_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(n_ptr);
    assign n_left      = (r_rdata[FIELD_W-1:0] == '0) ? '0 : r_rdata[FIELD_W-1:0] - 1'b1;
    assign n_fin       = (n_left == '0);
    assign n_head_next = (r_head[r_idx] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_head[r_idx] + 1'b1;
    assign n_tail_next = (r_tail[r_idx] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_tail[r_idx] + 1'b1;

    always_comb begin
        n_we    = 1'b0;
        n_wdata = {r_id, r_st};
        case (r_state)
            S_SCAN: begin
                n_we = n_fit && !n_full;
            end
            S_SERVE: begin
                n_we    = !n_fin;
                n_wdata = {r_rdata[ENT_W-1:FIELD_W], n_left};
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_addr] <= n_wdata;
        end
        r_rdata <= r_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PARTITIONS; i++) begin
                r_part_size[i] <= (i < NUM_REGS) ? SIZE_RESET[i] : '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < NUM_PARTITIONS; i++) begin
                if (i < NUM_REGS && i_cfg_index == REG_IDX_W'(i)) begin
                    r_part_size[i] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= 1'b0;
            r_tick_count <= '0;
            r_idx        <= '0;
            for (int i = 0; i < NUM_PARTITIONS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_id   <= i_s_axis_tdata[7:0];
                        r_st   <= (i_s_axis_tdata[15:8] == '0) ? FIELD_W'(1)
                                                               : i_s_axis_tdata[15:8];
                        r_size <= i_s_axis_tdata[23:16];
                        r_idx  <= '0;
                        r_state <= (t_cmd'(i_s_axis_tuser) == CMD_TICK) ? S_HEAD : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_kind                 <= KIND_ACK;
                    r_last                 <= 1'b1;
                    r_res.busy_res         <= 1'b0;
                    r_res.running_id       <= '0;
                    r_res.time_left        <= '0;
                    r_res.finished         <= 1'b0;
                    r_res.tick_time        <= r_tick_count;
                    if (n_fit) begin
                        r_res.partition_index <= 2'(r_idx);
                        if (n_full) begin
                            r_res.accepted     <= 1'b0;
                            r_res.reject_cause <= CAUSE_FULL;
                        end else begin
                            r_res.accepted     <= 1'b1;
                            r_res.reject_cause <= CAUSE_NONE;
                            r_tail[r_idx]      <= n_tail_next;
                            r_count[r_idx]     <= r_count[r_idx] + 1'b1;
                        end
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else if (n_last_part) begin
                        r_res.accepted        <= 1'b0;
                        r_res.reject_cause    <= CAUSE_NO_FIT;
                        r_res.partition_index <= '0;
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_HEAD: begin
                    r_kind                <= KIND_TICK;
                    r_last                <= n_last_part;
                    r_res.accepted        <= 1'b0;
                    r_res.reject_cause    <= CAUSE_NONE;
                    r_res.partition_index <= 2'(r_idx);
                    r_res.tick_time       <= r_tick_count;
                    r_res.busy_res        <= 1'b0;
                    r_res.running_id      <= '0;
                    r_res.time_left       <= '0;
                    r_res.finished        <= 1'b0;
                    if (r_count[r_idx] == '0) begin
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SERVE;
                    end
                end
                S_SERVE: begin
                    r_res.busy_res   <= 1'b1;
                    r_res.running_id <= r_rdata[ENT_W-1:FIELD_W];
                    r_res.time_left  <= n_left;
                    r_res.finished   <= n_fin;
                    if (n_fin) begin
                        r_head[r_idx]  <= n_head_next;
                        r_count[r_idx] <= r_count[r_idx] - 1'b1;
                    end
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_axis_tready) begin
                        r_valid <= 1'b0;
                        if (r_last) begin
                            if (r_kind == KIND_TICK) begin
                                r_tick_count <= r_tick_count + 1'b1;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_HEAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tuser  = r_kind;
    assign o_m_axis_tlast  = r_last;
    assign o_m_axis_tdata  = {1'b0, r_res.tick_time, r_res.finished, r_res.time_left,
                              r_res.running_id, r_res.busy_res, r_res.partition_index,
                              r_res.reject_cause, r_res.accepted};

    a_ready_excl_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("input ready while a result is pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[r_idx] <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ack_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_ACK) |-> o_m_axis_tlast)
        else $error("add acknowledgement not marked last");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast && o_m_axis_tuser == KIND_TICK)
        |=> r_tick_count == $past(r_tick_count) + 1'b1)
        else $error("tick counter did not advance after tick");

    a_served_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SERVE) |-> (r_count[r_idx] != '0))
        else $error("served an empty queue");

endmodule
